>>> rtl/glnm_pkg.sv
// ----------------------------------------------------------------------------
// glnm_pkg: shared types and constants of the nearest-unmatched matcher
// Command codes, field widths, stream packing widths and sequencer states.
// ----------------------------------------------------------------------------
package glnm_pkg;

  // Default sizing handed to the top level
  localparam int SLOTS_DEF        = 1024;
  localparam int FEATURE_BITS_DEF = 16;

  // Fixed field widths of the stream payloads
  localparam int CMD_W       = 2;
  localparam int IN_FEAT_W   = 16;
  localparam int ID_W        = 31;
  localparam int OUT_SLOT_W  = 10;
  localparam int OUT_DIST_W  = 18;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;

  // Command codes carried on in_tuser
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MATCH = 2'd2;

  // Query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MARK,
    ST_RESULT
  } glnm_state_t;

endpackage

>>> rtl/greedy_l1_nearest_unmatched_match.sv
// ----------------------------------------------------------------------------
// greedy_l1_nearest_unmatched_match: greedy nearest-unmatched L1 matcher
// Holds a candidate table, and per query scans the loaded, untaken slots for
// the least L1 feature distance, marks the winner taken and reports it.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata / tuser fields (low bit up)                 role
//  in_      in   tdata: fan_in, fan_out, reach_out_two_hop,        commands
//                reach_in_two_hop, node_id; tuser: command
//  out_     out  tdata: match_slot, matched_id, match_distance;    one per query
//                tuser: found
//
//  Clear and load leave the sequencer idle. A query holds the input off
//  from acceptance until its result is loaded (an empty table goes straight
//  to the result state): one slot per cycle is read from the candidate RAM
//  through the shared two-stage L1 unit, the pipeline drains, then the
//  taken mark is written and the result is loaded. Reset clears the count and
//  the sequencer; the candidate RAMs need no clearing pass, since each load
//  rewrites the taken mark of its slot. A result not yet taken holds in the
//  output register; the next query then waits in its result state, with the
//  input held off, until that register frees up.
//
module greedy_l1_nearest_unmatched_match
  import glnm_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int FEATURE_BITS = FEATURE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // fan_in, fan_out, reach_out_two_hop, reach_in_two_hop, node_id
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // match_slot, matched_id, match_distance
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic [0:0]             out_tuser
);

  localparam int FB      = FEATURE_BITS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int DIST_W  = FEATURE_BITS + 2;
  localparam int FEAT_W  = 4 * FEATURE_BITS;
  localparam int ENTRY_W = FEAT_W + ID_W;
  localparam int TAG_W   = ID_W + SLOT_W;

  glnm_state_t state_r, state_nxt;

  logic [CMD_W-1:0]   cmd;
  logic [FEAT_W-1:0]  in_feat;
  logic [ID_W-1:0]    in_id;
  logic               acc;
  logic               load_we;
  logic               last_issue;

  logic [CNT_W-1:0]   cnt_r;
  logic [SLOT_W-1:0]  addr_r;
  logic [FEAT_W-1:0]  query_r;
  logic               rd_v_r;
  logic [SLOT_W-1:0]  rd_slot_r;

  logic               issue;
  logic               mark_we;
  logic               out_load;

  logic [ENTRY_W-1:0] entry_rd;
  logic [0:0]         taken_rd;
  logic               taken_we;
  logic [SLOT_W-1:0]  taken_waddr;

  logic               l1_valid;
  logic [DIST_W-1:0]  l1_dist;
  logic [TAG_W-1:0]   l1_tag;
  logic               l1_busy;

  logic               have_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [SLOT_W-1:0]  best_slot_r;
  logic [ID_W-1:0]    best_id_r;

  logic                         out_tvalid_r;
  logic                         found_r;
  logic [OUT_SLOT_W-1:0]        slot_out_r;
  logic [ID_W-1:0]              id_out_r;
  logic [OUT_DIST_W-1:0]        dist_out_r;
  logic [SLOT_W+OUT_SLOT_W-1:0] slot_ext;
  logic [DIST_W+OUT_DIST_W-1:0] dist_ext;

  // Unpack the input transaction
  assign cmd   = in_tuser;
  assign in_id = in_tdata[4*IN_FEAT_W +: ID_W];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_feat[k*FB +: FB] = in_tdata[k*IN_FEAT_W +: FB];
    end
  end

  assign acc        = in_tvalid && in_tready;
  assign load_we    = acc && (cmd == CMD_LOAD) && (cnt_r < CNT_W'(SLOTS));
  assign last_issue = (CNT_W'(addr_r) + CNT_W'(1)) == cnt_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (cmd == CMD_MATCH)) begin
          state_nxt = (cnt_r == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !l1_busy) begin
          state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    mark_we   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_SCAN:   issue     = 1'b1;
      ST_DRAIN:  ;
      ST_MARK:   mark_we   = have_r;
      ST_RESULT: out_load  = !out_tvalid_r || out_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Loaded count: clear drops it, a load into free room advances it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc && (cmd == CMD_CLEAR)) begin
      cnt_r <= '0;
    end else if (load_we) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Scan address and read-valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      if (acc) begin
        addr_r <= '0;
      end else if (issue) begin
        addr_r <= addr_r + SLOT_W'(1);
      end
    end
  end

  // Hold the query features and the slot of the outstanding read
  always_ff @(posedge clk) begin
    if (acc && (cmd == CMD_MATCH)) begin
      query_r <= in_feat;
    end
    rd_slot_r <= addr_r;
  end

  // Candidate features and id, written in slot order on load
  glnm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (cnt_r[SLOT_W-1:0]),
    .wdata ({in_id, in_feat}),
    .raddr (addr_r),
    .rdata (entry_rd)
  );

  // Taken marks: cleared when a slot is loaded, set when it wins
  assign taken_we    = load_we || mark_we;
  assign taken_waddr = mark_we ? best_slot_r : cnt_r[SLOT_W-1:0];

  glnm_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_taken_ram (
    .clk   (clk),
    .we    (taken_we),
    .waddr (taken_waddr),
    .wdata (mark_we),
    .raddr (addr_r),
    .rdata (taken_rd)
  );

  // Shared distance unit, fed only with untaken slots
  glnm_l1 #(
    .FEATURE_BITS (FEATURE_BITS),
    .TAG_W        (TAG_W)
  ) u_l1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_v_r && !taken_rd[0]),
    .query     (query_r),
    .cand      (entry_rd[FEAT_W-1:0]),
    .tag_in    ({entry_rd[FEAT_W +: ID_W], rd_slot_r}),
    .out_valid (l1_valid),
    .sum_out   (l1_dist),
    .tag_out   (l1_tag),
    .busy      (l1_busy)
  );

  // Track the best candidate; strict less keeps the lowest slot on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (acc) begin
      have_r <= 1'b0;
    end else if (l1_valid) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (l1_valid && (!have_r || (l1_dist < best_dist_r))) begin
      best_dist_r <= l1_dist;
      best_slot_r <= l1_tag[SLOT_W-1:0];
      best_id_r   <= l1_tag[SLOT_W +: ID_W];
    end
  end

  // Fit slot and distance into the result field widths
  assign slot_ext = {{OUT_SLOT_W{1'b0}}, best_slot_r};
  assign dist_ext = {{OUT_DIST_W{1'b0}}, best_dist_r};

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found_r    <= have_r;
      slot_out_r <= have_r ? slot_ext[OUT_SLOT_W-1:0] : '0;
      id_out_r   <= have_r ? best_id_r : '0;
      dist_out_r <= have_r ? dist_ext[OUT_DIST_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_DIST_W - ID_W - OUT_SLOT_W){1'b0}},
                       dist_out_r, id_out_r, slot_out_r};

  // The loaded count never passes the table size
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("loaded count beyond table size");

  // The scan only reads loaded slots
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(addr_r) < cnt_r))
    else $error("scan address beyond loaded count");

  // The taken mark is written only after the distance pipeline has emptied
  a_mark_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> ($past(state_r) == ST_DRAIN) && !rd_v_r && !l1_busy)
    else $error("taken mark written with scan in flight");

  // A result without a match carries an all-zero payload
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !found_r) |-> (out_tdata == '0))
    else $error("unmatched result with nonzero payload");

endmodule

>>> rtl/glnm_ram.sv
// ----------------------------------------------------------------------------
// glnm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module glnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/glnm_l1.sv
// ----------------------------------------------------------------------------
// glnm_l1: two-stage L1 distance unit
// Stage one takes four absolute feature differences, stage two sums them.
// A tag rides along with each operand pair.
// ----------------------------------------------------------------------------
module glnm_l1 #(
  parameter int FEATURE_BITS = 16,
  parameter int TAG_W        = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [4*FEATURE_BITS-1:0] query,
  input  logic [4*FEATURE_BITS-1:0] cand,
  input  logic [TAG_W-1:0]          tag_in,
  output logic                      out_valid,
  output logic [FEATURE_BITS+1:0]   sum_out,
  output logic [TAG_W-1:0]          tag_out,
  output logic                      busy
);

  localparam int FB     = FEATURE_BITS;
  localparam int DIST_W = FEATURE_BITS + 2;

  logic [FB-1:0]     diff_nxt [4];
  logic [FB-1:0]     diff_r   [4];
  logic              v1_r;
  logic [TAG_W-1:0]  tag1_r;
  logic [DIST_W-1:0] sum_nxt;
  logic [DIST_W-1:0] sum_r;
  logic              v2_r;
  logic [TAG_W-1:0]  tag2_r;

  // Absolute difference per feature lane
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (query[k*FB +: FB] >= cand[k*FB +: FB]) begin
        diff_nxt[k] = query[k*FB +: FB] - cand[k*FB +: FB];
      end else begin
        diff_nxt[k] = cand[k*FB +: FB] - query[k*FB +: FB];
      end
    end
  end

  // Sum the four lane differences
  always_comb begin
    sum_nxt = ({2'b00, diff_r[0]} + {2'b00, diff_r[1]})
            + ({2'b00, diff_r[2]} + {2'b00, diff_r[3]});
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      diff_r[k] <= diff_nxt[k];
    end
    tag1_r <= tag_in;
    sum_r  <= sum_nxt;
    tag2_r <= tag1_r;
  end

  assign out_valid = v2_r;
  assign sum_out   = sum_r;
  assign tag_out   = tag2_r;
  assign busy      = v1_r | v2_r;

endmodule
